>>> src/t8cpu_pkg.sv
// Package for the eight-bit soft core: payload structs, opcode groups and status codes.
// Depends on nothing; every module of the core imports it.
package t8cpu_pkg;

   typedef struct packed {
      logic [15:0] instr_word;
      logic [7:0]  port_in_data;
   } req_type;

   typedef struct packed {
      logic [7:0] next_pc;
      logic [7:0] port_id;
      logic [7:0] port_out_data;
      logic       write_strobe;
      logic       read_strobe;
      logic       zero_flag;
      logic       carry_flag;
      logic       irq_enable;
      logic [1:0] exec_status;
   } rsp_type;

   // Decoded operation class, produced by the front end.
   typedef enum logic [3:0] {
      OP_LOAD, OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB, OP_IN, OP_OUT,
      OP_RET, OP_SHIFT, OP_RETI, OP_JUMP, OP_CALL, OP_INTR, OP_BAD
   } op_type;

   // Classified instruction passed from front end to back end.
   typedef struct packed {
      op_type     op;
      logic       use_reg_b;
      logic       with_carry;
      logic [2:0] rx;
      logic [2:0] ry;
      logic [7:0] kk;
      logic [7:0] pin;
   } dec_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_OP  = 2'd1;
   localparam logic [1:0] ST_NO_CALL = 2'd2;

   localparam logic [15:0] RETI_EN   = 16'hb000;
   localparam logic [15:0] RETI_DIS  = 16'hb001;
   localparam logic [15:0] INTR_EN   = 16'hf000;
   localparam logic [15:0] INTR_DIS  = 16'hf001;

   // Shift and rotate codes.
   localparam logic [7:0] SH_SLA = 8'h00;
   localparam logic [7:0] SH_SLX = 8'h02;
   localparam logic [7:0] SH_RL  = 8'h04;
   localparam logic [7:0] SH_SL0 = 8'h06;
   localparam logic [7:0] SH_SL1 = 8'h07;
   localparam logic [7:0] SH_SRA = 8'h08;
   localparam logic [7:0] SH_SRX = 8'h0a;
   localparam logic [7:0] SH_RR  = 8'h0c;
   localparam logic [7:0] SH_SR0 = 8'h0e;
   localparam logic [7:0] SH_SR1 = 8'h0f;

endpackage

>>> src/tiny_8bit_soft_cpu_core.sv
// Top level of the eight-bit soft core: front-end decoder and back-end executor.
// Depends on t8cpu_pkg, t8cpu_front and t8cpu_back.
//
// Usage: push an instruction word and the input port value while full is low.
// Each instruction gives exactly one result: next fetch address, port strobes,
// port address and data, flags and an execution status.
// The result reaches the rsp_ ports after the input transfer by way of two
// register stages (decode register, then execute into the output register).
// Throughput is one instruction per cycle when pop keeps up; the
// register file read, ALU and write-back form one loop in the back end,
// closed through the state registers, which sets that limit.
// When the receiver stalls, the output register and the one-entry decode queue
// fill, after which full rises; no item is lost.
// Synchronous reset clears registers, stack, PC, flags and call count and empties
// both queues; the block accepts items in the first cycle after reset.
module tiny_8bit_soft_cpu_core #(
   parameter int STACK_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  t8cpu_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output t8cpu_pkg::rsp_type rsp_data
);
   import t8cpu_pkg::*;

   logic    dec_valid, dec_take;
   dec_type dec_data;

   t8cpu_front u_front (
      .clock, .reset, .push, .full, .req_data,
      .dec_valid, .dec_take, .dec_data
   );

   t8cpu_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock, .reset, .dec_valid, .dec_take, .dec_data,
      .empty, .pop, .rsp_data
   );
endmodule

>>> src/t8cpu_front.sv
// Front end: accepts instruction words, classifies them and holds one decoded entry.
// Depends on t8cpu_pkg.
module t8cpu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  t8cpu_pkg::req_type  req_data,
   output logic                dec_valid,
   input  logic                dec_take,
   output t8cpu_pkg::dec_type  dec_data
);
   import t8cpu_pkg::*;

   logic    valid_ff, valid_in;
   dec_type data_ff, data_in;
   dec_type cls;
   logic [4:0] grp;
   logic [15:0] w;

   // Classify the opcode group.
   always_comb begin
      w = req_data.instr_word;
      grp = w[15:11];
      cls.use_reg_b  = grp[3];
      cls.with_carry = grp[0];
      cls.rx  = w[10:8];
      cls.ry  = w[7:5];
      cls.kk  = w[7:0];
      cls.pin = req_data.port_in_data;
      unique case (grp)
         5'd0, 5'd8:                 cls.op = OP_LOAD;
         5'd1, 5'd9:                 cls.op = OP_AND;
         5'd2, 5'd10:                cls.op = OP_OR;
         5'd3, 5'd11:                cls.op = OP_XOR;
         5'd4, 5'd5, 5'd12, 5'd13:   cls.op = OP_ADD;
         5'd6, 5'd7, 5'd14, 5'd15:   cls.op = OP_SUB;
         5'd16, 5'd24:               cls.op = OP_IN;
         5'd17, 5'd25:               cls.op = OP_OUT;
         5'd18:                      cls.op = OP_RET;
         5'd20:                      cls.op = OP_SHIFT;
         5'd22: cls.op = (w == RETI_EN || w == RETI_DIS) ? OP_RETI : OP_BAD;
         5'd26:                      cls.op = OP_JUMP;
         5'd27:                      cls.op = OP_CALL;
         5'd30: cls.op = (w == INTR_EN || w == INTR_DIS) ? OP_INTR : OP_BAD;
         default:                    cls.op = OP_BAD;
      endcase
   end

   // One-entry queue toward the back end; refills in the cycle it drains.
   assign full = valid_ff && !dec_take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (dec_take) valid_in = 1'b0;
      if (push && !full) begin
         valid_in = 1'b1;
         data_in  = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end

   assign dec_valid = valid_ff;
   assign dec_data  = data_ff;
endmodule

>>> src/t8cpu_back.sv
// Back end: executes decoded instructions against the architectural state.
// Depends on t8cpu_pkg.
module t8cpu_back #(
   parameter int STACK_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                dec_valid,
   output logic                dec_take,
   input  t8cpu_pkg::dec_type  dec_data,
   output logic                empty,
   input  logic                pop,
   output t8cpu_pkg::rsp_type  rsp_data
);
   import t8cpu_pkg::*;

   localparam int SP_W = $clog2(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

   logic [7:0]      regs_ff [8];
   logic [7:0]      stack_ff [STACK_DEPTH];
   logic [7:0]      pc_ff;
   logic [SP_W-1:0] sp_ff;
   logic            z_ff, c_ff, ie_ff;
   logic [7:0]      calls_ff;
   logic            out_valid_ff;
   rsp_type         out_ff;

   logic [7:0]      a, b, res, pc1, pc_in, calls_in, pid, pout;
   logic [8:0]      sum;
   logic            z_in, c_in, ie_in, wr_reg, cond, wr, rd;
   logic [1:0]      st;
   logic            push_stk, pop_stk;
   logic [SP_W-1:0] sp_dec, sp_inc, sp_in;
   logic [7:0]      sh_v;

   // Output register: accept a new item whenever it is empty or the held result leaves.
   assign dec_take = dec_valid && (!out_valid_ff || pop);
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      a      = regs_ff[dec_data.rx];
      b      = dec_data.use_reg_b ? regs_ff[dec_data.ry] : dec_data.kk;
      pc1    = pc_ff + 8'd1;
      // The call stack is circular over its depth, which need not be a power of two.
      sp_dec = (sp_ff == '0) ? SP_LAST : sp_ff - SP_W'(1);
      sp_inc = (sp_ff == SP_LAST) ? '0 : sp_ff + SP_W'(1);
      unique case (dec_data.rx)
         3'd4:    cond = z_ff;
         3'd5:    cond = !z_ff;
         3'd6:    cond = c_ff;
         3'd7:    cond = !c_ff;
         default: cond = 1'b1;
      endcase
      res = 8'd0; sum = 9'd0;
      z_in = z_ff; c_in = c_ff; ie_in = ie_ff; pc_in = pc1; calls_in = calls_ff;
      wr_reg = 1'b0; pid = 8'd0; pout = 8'd0; wr = 1'b0; rd = 1'b0; st = ST_OK;
      push_stk = 1'b0; pop_stk = 1'b0; sh_v = a;
      unique case (dec_data.op)
         OP_LOAD: begin res = b; wr_reg = 1'b1; end
         OP_AND: begin res = a & b; wr_reg = 1'b1; c_in = 1'b0; z_in = (res == 8'd0); end
         OP_OR:  begin res = a | b; wr_reg = 1'b1; c_in = 1'b0; z_in = (res == 8'd0); end
         OP_XOR: begin res = a ^ b; wr_reg = 1'b1; c_in = 1'b0; z_in = (res == 8'd0); end
         OP_ADD: begin
            sum = {1'b0, a} + {1'b0, b} + {8'd0, dec_data.with_carry & c_ff};
            res = sum[7:0]; c_in = sum[8]; wr_reg = 1'b1; z_in = (res == 8'd0);
         end
         OP_SUB: begin
            sum = {1'b0, a} - {1'b0, b} - {8'd0, dec_data.with_carry & c_ff};
            res = sum[7:0]; c_in = sum[8]; wr_reg = 1'b1; z_in = (res == 8'd0);
         end
         OP_IN: begin
            res = dec_data.pin; wr_reg = 1'b1; rd = 1'b1;
            pid = dec_data.use_reg_b ? regs_ff[dec_data.ry] : dec_data.kk;
         end
         OP_OUT: begin
            pid = dec_data.use_reg_b ? regs_ff[dec_data.ry] : dec_data.kk;
            pout = a; wr = 1'b1;
         end
         OP_RET: if (cond) begin
            pop_stk = 1'b1; pc_in = stack_ff[sp_dec];
            if (calls_ff == 8'd0) st = ST_NO_CALL;
            else calls_in = calls_ff - 8'd1;
         end
         OP_RETI: begin
            pop_stk = 1'b1; pc_in = stack_ff[sp_dec]; ie_in = !dec_data.kk[0];
         end
         OP_JUMP: if (cond) pc_in = dec_data.kk;
         OP_CALL: if (cond) begin
            push_stk = 1'b1; pc_in = dec_data.kk;
            if (calls_ff != 8'hff) calls_in = calls_ff + 8'd1;
         end
         OP_INTR: ie_in = !dec_data.kk[0];
         OP_SHIFT: begin
            wr_reg = 1'b1; c_in = dec_data.kk[3] ? sh_v[0] : sh_v[7];
            case (dec_data.kk)
               SH_SLA: res = {sh_v[6:0], c_ff};
               SH_SLX: res = {sh_v[6:0], sh_v[0]};
               SH_RL:  res = {sh_v[6:0], sh_v[7]};
               SH_SL0: res = {sh_v[6:0], 1'b0};
               SH_SL1: res = {sh_v[6:0], 1'b1};
               SH_SRA: res = {c_ff, sh_v[7:1]};
               SH_SRX: res = {sh_v[7], sh_v[7:1]};
               SH_RR:  res = {sh_v[0], sh_v[7:1]};
               SH_SR0: res = {1'b0, sh_v[7:1]};
               SH_SR1: res = {1'b1, sh_v[7:1]};
               default: begin
                  wr_reg = 1'b0; c_in = c_ff; st = ST_BAD_OP;
               end
            endcase
            if (wr_reg) z_in = (res == 8'd0);
         end
         default: st = ST_BAD_OP;
      endcase
      sp_in = push_stk ? sp_inc : (pop_stk ? sp_dec : sp_ff);
   end

   // State update and result capture on each executed instruction.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 8'd0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 8'd0;
         pc_ff <= 8'd0; sp_ff <= '0; z_ff <= 1'b0; c_ff <= 1'b0;
         ie_ff <= 1'b0; calls_ff <= 8'd0; out_valid_ff <= 1'b0;
      end else begin
         if (pop && out_valid_ff) out_valid_ff <= 1'b0;
         if (dec_take) begin
            if (wr_reg) regs_ff[dec_data.rx] <= res;
            if (push_stk) stack_ff[sp_ff] <= pc1;
            pc_ff <= pc_in; sp_ff <= sp_in; z_ff <= z_in; c_ff <= c_in;
            ie_ff <= ie_in; calls_ff <= calls_in; out_valid_ff <= 1'b1;
         end
      end
      if (dec_take)
         out_ff <= '{next_pc: pc_in, port_id: pid, port_out_data: pout,
                     write_strobe: wr, read_strobe: rd, zero_flag: z_in,
                     carry_flag: c_in, irq_enable: ie_in, exec_status: st};
   end
endmodule

>>> tb/cpu_result_checker.sv
// Checker for the eight-bit soft core: watches both channels, predicts each result and compares.
// Depends on t8cpu_pkg; instantiated by the testbench top beside the core.
module cpu_result_checker #(
   parameter int STACK_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  t8cpu_pkg::req_type req_data,
   input  logic               empty,
   input  logic               pop,
   input  t8cpu_pkg::rsp_type rsp_data,
   output int                 error_count,
   output int                 pending_count
);
   import t8cpu_pkg::*;

   // Shadow copy of the core's architectural state.
   logic [7:0] regs [8];
   logic [7:0] pc;
   logic [7:0] stack [STACK_DEPTH];
   int         sp;
   logic       zf, cf, ie;
   logic [7:0] calls;

   rsp_type expected_results [$];

   // Conditions 4 to 7 test the flags; the rest are always taken.
   function automatic logic cond_taken(input logic [2:0] c);
      case (c)
         3'd4: return zf;
         3'd5: return !zf;
         3'd6: return cf;
         3'd7: return !cf;
         default: return 1'b1;
      endcase
   endfunction

   function automatic logic [7:0] pop_return();
      sp = (sp + STACK_DEPTH - 1) % STACK_DEPTH;
      return stack[sp];
   endfunction

   // Executes one instruction on the shadow state and returns its result.
   function automatic rsp_type execute_instr(input req_type rq);
      logic [15:0] w;
      logic [4:0]  grp;
      logic [2:0]  x, y;
      logic [7:0]  k, a, b, r8;
      logic [8:0]  r9;
      rsp_type     rs;
      w   = rq.instr_word;
      grp = w[15:11];
      x   = w[10:8];
      y   = w[7:5];
      k   = w[7:0];
      a   = regs[x];
      b   = grp[3] ? regs[y] : k;
      rs  = '0;
      rs.exec_status = ST_OK;
      pc  = pc + 8'd1;
      case (grp)
         5'd0, 5'd8: regs[x] = b;
         5'd1, 5'd9, 5'd2, 5'd10, 5'd3, 5'd11: begin
            if (grp[1:0] == 2'd1) r8 = a & b;
            else if (grp[1:0] == 2'd2) r8 = a | b;
            else r8 = a ^ b;
            cf = 1'b0;
            regs[x] = r8;
            zf = (r8 == 8'd0);
         end
         5'd4, 5'd5, 5'd12, 5'd13, 5'd6, 5'd7, 5'd14, 5'd15: begin
            if (grp[1]) r9 = {1'b0, a} - {1'b0, b} - {8'd0, grp[0] & cf};
            else r9 = {1'b0, a} + {1'b0, b} + {8'd0, grp[0] & cf};
            cf = r9[8];
            regs[x] = r9[7:0];
            zf = (r9[7:0] == 8'd0);
         end
         5'd16, 5'd24: begin
            rs.port_id = (grp == 5'd24) ? regs[y] : k;
            rs.read_strobe = 1'b1;
            regs[x] = rq.port_in_data;
         end
         5'd17, 5'd25: begin
            rs.port_id = (grp == 5'd25) ? regs[y] : k;
            rs.port_out_data = a;
            rs.write_strobe = 1'b1;
         end
         5'd18: if (cond_taken(x)) begin
            if (calls == 8'd0) rs.exec_status = ST_NO_CALL;
            else calls = calls - 8'd1;
            pc = pop_return();
         end
         5'd20: begin
            case (k)
               SH_SLA: begin r8 = {a[6:0], cf};    cf = a[7]; end
               SH_SLX: begin r8 = {a[6:0], a[0]};  cf = a[7]; end
               SH_RL:  begin r8 = {a[6:0], a[7]};  cf = a[7]; end
               SH_SL0: begin r8 = {a[6:0], 1'b0};  cf = a[7]; end
               SH_SL1: begin r8 = {a[6:0], 1'b1};  cf = a[7]; end
               SH_SRA: begin r8 = {cf, a[7:1]};    cf = a[0]; end
               SH_SRX: begin r8 = {a[7], a[7:1]};  cf = a[0]; end
               SH_RR:  begin r8 = {a[0], a[7:1]};  cf = a[0]; end
               SH_SR0: begin r8 = {1'b0, a[7:1]};  cf = a[0]; end
               SH_SR1: begin r8 = {1'b1, a[7:1]};  cf = a[0]; end
               default: rs.exec_status = ST_BAD_OP;
            endcase
            if (rs.exec_status == ST_OK) begin
               regs[x] = r8;
               zf = (r8 == 8'd0);
            end
         end
         5'd22: begin
            if (w == RETI_EN || w == RETI_DIS) begin
               ie = (w == RETI_EN);
               pc = pop_return();
            end else begin
               rs.exec_status = ST_BAD_OP;
            end
         end
         5'd26: if (cond_taken(x)) pc = k;
         5'd27: if (cond_taken(x)) begin
            stack[sp] = pc;
            sp = (sp + 1) % STACK_DEPTH;
            pc = k;
            if (calls != 8'hff) calls = calls + 8'd1;
         end
         5'd30: begin
            if (w == INTR_EN || w == INTR_DIS) ie = (w == INTR_EN);
            else rs.exec_status = ST_BAD_OP;
         end
         default: rs.exec_status = ST_BAD_OP;
      endcase
      rs.next_pc    = pc;
      rs.zero_flag  = zf;
      rs.carry_flag = cf;
      rs.irq_enable = ie;
      return rs;
   endfunction

   assign pending_count = expected_results.size();

   // Predict on each input transfer, compare on each result transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         foreach (stack[i]) stack[i] = '0;
         pc = '0; sp = 0; zf = 0; cf = 0; ie = 0; calls = '0;
         expected_results.delete();
         error_count = 0;
      end else begin
         if (push && !full) expected_results.push_back(execute_instr(req_data));
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= 10)
                  $display("Unexpected result transfer: %h", rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_data) begin
                  error_count = error_count + 1;
                  if (error_count <= 10)
                     $display("Mismatch: pc %h/%h id %h/%h out %h/%h wr %b/%b rd %b/%b z %b/%b c %b/%b ie %b/%b st %0d/%0d",
                        want.next_pc, rsp_data.next_pc, want.port_id, rsp_data.port_id,
                        want.port_out_data, rsp_data.port_out_data,
                        want.write_strobe, rsp_data.write_strobe,
                        want.read_strobe, rsp_data.read_strobe,
                        want.zero_flag, rsp_data.zero_flag,
                        want.carry_flag, rsp_data.carry_flag,
                        want.irq_enable, rsp_data.irq_enable,
                        want.exec_status, rsp_data.exec_status);
               end
            end
         end
      end
   end

endmodule

>>> tb/testbench.sv
// Testbench top for the eight-bit soft core: clock, reset, instruction stimulus and verdict.
// Depends on t8cpu_pkg, tiny_8bit_soft_cpu_core and cpu_result_checker.
module testbench;
   import t8cpu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full, empty;
   req_type req_data = '0;
   rsp_type rsp_data;
   int      error_count, pending_count;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   always #4 clock = ~clock;

   tiny_8bit_soft_cpu_core u_top (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   cpu_result_checker u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   // The receiver stalls at random, changing pop at the falling edge.
   always @(negedge clock) begin
      if (!reset) pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Sends one instruction and holds it until the transfer happens.
   // Push stays high afterward so that the next instruction can follow directly.
   task automatic send_instr(input logic [15:0] w, input logic [7:0] pin);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_data <= '{instr_word: w, port_in_data: pin};
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   // Drops push so that no further transfer happens.
   task automatic stop_sending();
      push <= 1'b0;
      @(negedge clock);
   endtask

   // Random instruction, biased toward defined operations with random content.
   function automatic logic [15:0] random_instr();
      logic [15:0] w;
      logic [7:0]  shifts [10];
      int          pick;
      shifts = '{SH_SLA, SH_SLX, SH_RL, SH_SL0, SH_SL1, SH_SRA, SH_SRX, SH_RR, SH_SR0,
                 SH_SR1};
      w = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 15) w = {5'd20, w[10:8], shifts[$urandom_range(9)]};
      else if (pick < 20) w = $urandom_range(1) ? {w[15:1], 1'b0} & 16'hf001 | RETI_EN
                                                : (w[0] ? INTR_DIS : INTR_EN);
      else if (pick < 24) w = w[0] ? RETI_DIS : RETI_EN;
      else if (pick < 30) w = {5'd27, w[10:0]};
      else if (pick < 36) w = {5'd18, w[10:0]};
      else if (pick < 80) w = {1'b0, w[14:0]};
      return w;
   endfunction

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: every operation class, extremes, shifts, bad codes and stack cases.
      send_instr(16'h00ff, 8'h00);   // load s0, ff
      send_instr(16'h20ff, 8'h00);   // add s0, ff -> carry
      send_instr(16'h2801, 8'h00);   // addcy
      send_instr(16'h3001, 8'h00);   // sub borrow
      send_instr(16'h3800, 8'h00);   // subcy
      send_instr(16'h0855, 8'h00);   // and
      send_instr(16'h10aa, 8'h00);   // or
      send_instr(16'h18ff, 8'h00);   // xor
      send_instr(16'h4120, 8'h00);   // register-form load s1, s1
      send_instr(16'h8200, 8'hff);   // input s2, port 00
      send_instr(16'hc320, 8'ha5);   // input s3, port s1
      send_instr(16'h8aff, 8'h00);   // output s2, port ff
      send_instr(16'hcb40, 8'h00);   // output s3, port s2
      send_instr({5'd20, 3'd2, SH_SR1}, 8'h00);
      send_instr({5'd20, 3'd2, SH_RR}, 8'h00);
      send_instr({5'd20, 3'd2, 8'h01}, 8'h00);   // undefined shift code
      send_instr(16'h9000, 8'h00);   // return with no open call
      send_instr(16'hd8f0, 8'h00);   // call f0
      send_instr(16'hd810, 8'h00);
      send_instr(16'hd820, 8'h00);
      send_instr(16'hd830, 8'h00);
      send_instr(16'hd840, 8'h00);   // stack wraps
      send_instr(RETI_EN, 8'h00);
      send_instr(16'hb002, 8'h00);   // bad returni
      send_instr(INTR_DIS, 8'h00);
      send_instr(16'hf0ff, 8'h00);   // bad interrupt code
      send_instr(16'he000, 8'h00);   // unused group
      send_instr(16'hd4ff, 8'h00);   // jump if zero

      // Random part in three idling phases, with one full drain after the first phase.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 8 : 0;
         repeat (610) send_instr(random_instr(), 8'($urandom));
         if (phase == 0) begin
            stop_sending();
            while (pending_count != 0) @(negedge clock);
         end
      end

      stop_sending();
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
